### rtl/min_max_span_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Span tracker assertion macros
// Concurrent check helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_SPAN_TRACKER_UNIT_DEFINES_SVH
`define MIN_MAX_SPAN_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MMST_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("span tracker check failed");
`define MMST_NEVER(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("span tracker forbidden condition");
`else
`define MMST_ASSERT(name, prop)
`define MMST_NEVER(name, expr)
`endif

`endif

### rtl/mmst_pkg.sv
// ----------------------------------------------------------------------------
// Span tracker package
// Shared codes, widths and the structs passed between cells.
// ----------------------------------------------------------------------------
package mmst_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam logic [6:0]  CAP_RESET     = 7'd64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REPEAT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_FEW      = 2'd2;

    localparam logic [31:0] BIAS    = 32'h8000_0000;
    localparam logic [32:0] NO_PAIR = {33{1'b1}};

    // Probe walking down the chain: new value and smallest gap so far
    typedef struct packed {
        logic        vld;
        logic [31:0] val;
        logic [6:0]  lim;
        logic [32:0] gap;
    } t_probe;

    // Store write broadcast: fill cells lo .. hi-1 with val
    typedef struct packed {
        logic        en;
        logic [31:0] val;
        logic [6:0]  lo;
        logic [7:0]  hi;
    } t_wr;

endpackage

### rtl/mmst_if.sv
// ----------------------------------------------------------------------------
// Span tracker channels
// Valid/ready channels for commands, results and the capacity write.
// ----------------------------------------------------------------------------
interface mmst_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         repeat_count;

    modport source (output valid, cmd, value, repeat_count, input ready);
    modport sink   (input valid, cmd, value, repeat_count, output ready);
endinterface

interface mmst_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] shortest_span;
    logic [31:0] longest_span;
    logic [6:0]  stored_count;

    modport source (output valid, status, shortest_span, longest_span, stored_count,
                    input ready);
    modport sink   (input valid, status, shortest_span, longest_span, stored_count,
                    output ready);
endinterface

interface mmst_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/mmst_cell.sv
// ----------------------------------------------------------------------------
// Span tracker cell
// Holds one stored value; folds its distance to the passing probe into the gap.
// ----------------------------------------------------------------------------
module mmst_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmst_pkg::t_probe i_probe,
    input  mmst_pkg::t_wr    i_wr,
    output mmst_pkg::t_probe o_probe
);

    localparam logic [6:0] ID = 7'(IDX);

    logic [31:0] r_val;
    logic        r_vld;
    logic [31:0] r_pval;
    logic [6:0]  r_plim;
    logic [32:0] r_pgap;
    logic        occ;
    logic [31:0] delta;
    logic [32:0] n_gap;
    logic        wr_hit;

    assign occ    = i_probe.vld && (ID < i_probe.lim);
    assign delta  = (i_probe.val >= r_val) ? (i_probe.val - r_val) : (r_val - i_probe.val);
    assign n_gap  = (occ && ({1'b0, delta} < i_probe.gap)) ? {1'b0, delta} : i_probe.gap;
    assign wr_hit = i_wr.en && (ID >= i_wr.lo) && ({1'b0, ID} < i_wr.hi);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_val <= i_wr.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_probe.vld;
        end
    end

    // advance the probe payload one cell
    always_ff @(posedge i_clk) begin
        r_pval <= i_probe.val;
        r_plim <= i_probe.lim;
        r_pgap <= n_gap;
    end

    always_comb begin
        o_probe.vld = r_vld;
        o_probe.val = r_pval;
        o_probe.lim = r_plim;
        o_probe.gap = r_pgap;
    end

endmodule

### rtl/min_max_span_tracker_unit.sv
// ----------------------------------------------------------------------------
// Span tracker top: the result of each command beat is registered.
// Adds and rejected items take one beat per cycle when the result side is free;
// each store launches a probe that walks min(DEPTH,127) cells, one per cycle,
// to refresh the shortest gap. A query stalls until all probes have left.
// Reset (sync, active low) empties the store, clears spans, sets capacity 64.
// ----------------------------------------------------------------------------
`include "min_max_span_tracker_unit_defines.svh"

module min_max_span_tracker_unit #(
    parameter int unsigned DEPTH = mmst_pkg::DEPTH_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mmst_cmd_if.sink   i_cmd_ch,
    mmst_res_if.source o_res_ch,
    mmst_cfg_if.sink   i_cfg_ch
);

    localparam int unsigned CELLS   = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [6:0]  CAP_MAX = 7'(CELLS);
    localparam int unsigned IW      = $clog2(CELLS + 2);

    logic [6:0]  r_cap;
    logic [6:0]  r_fill;
    logic [31:0] r_min;
    logic [31:0] r_max;
    logic [32:0] r_gap;
    logic [IW-1:0] r_inflight;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_short;
    logic [31:0] r_long;
    logic [6:0]  r_count;

    logic [6:0]  cap_eff;
    logic [31:0] b;
    logic [7:0]  sum_rpt;
    logic [7:0]  fill_inc;
    logic        add_ok;
    logic        rep_ok;
    logic        out_free;
    logic        in_acc;
    logic        store;
    logic [6:0]  n_fill;
    logic [1:0]  n_status;
    logic [31:0] n_short;
    logic [31:0] n_long;

    mmst_pkg::t_probe w_link [CELLS+1];
    mmst_pkg::t_wr    wr;

    assign cap_eff  = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign b        = i_cmd_ch.value ^ mmst_pkg::BIAS;
    assign sum_rpt  = {1'b0, r_fill} + {1'b0, i_cmd_ch.repeat_count};
    assign fill_inc = {1'b0, r_fill} + 8'd1;
    assign add_ok   = (i_cmd_ch.cmd == mmst_pkg::CMD_ADD) && (r_fill < cap_eff);
    assign rep_ok   = (i_cmd_ch.cmd == mmst_pkg::CMD_REPEAT) &&
                      (i_cmd_ch.repeat_count != 7'd0) && (sum_rpt <= {1'b0, cap_eff});

    assign out_free        = !r_out_valid || o_res_ch.ready;
    // hold a query until every probe has left the chain
    assign i_cmd_ch.ready  = out_free &&
                             !((i_cmd_ch.cmd == mmst_pkg::CMD_QUERY) && (r_inflight != '0));
    assign in_acc          = i_cmd_ch.valid && i_cmd_ch.ready;
    assign store           = in_acc && (add_ok || rep_ok);
    assign n_fill          = add_ok ? fill_inc[6:0] : sum_rpt[6:0];

    assign i_cfg_ch.ready = 1'b1;

    // store write and probe launch
    always_comb begin
        wr.en  = store;
        wr.val = b;
        wr.lo  = r_fill;
        wr.hi  = add_ok ? fill_inc : sum_rpt;

        w_link[0].vld = store;
        w_link[0].val = b;
        w_link[0].lim = r_fill;
        // copies of one value among themselves give a zero gap
        w_link[0].gap = (rep_ok && (i_cmd_ch.repeat_count > 7'd1)) ? '0 : mmst_pkg::NO_PAIR;
    end

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        mmst_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_link[g]),
            .i_wr    (wr),
            .o_probe (w_link[g+1])
        );
    end

    always_comb begin
        n_status = mmst_pkg::ST_OK;
        n_short  = '0;
        n_long   = '0;
        case (i_cmd_ch.cmd)
            mmst_pkg::CMD_ADD: begin
                if (!add_ok) n_status = mmst_pkg::ST_OVERFLOW;
            end
            mmst_pkg::CMD_REPEAT: begin
                if (!rep_ok) n_status = mmst_pkg::ST_OVERFLOW;
            end
            mmst_pkg::CMD_QUERY: begin
                if (r_fill < 7'd2) begin
                    n_status = mmst_pkg::ST_FEW;
                end else begin
                    n_short = r_gap[31:0];
                    n_long  = r_max - r_min;
                end
            end
            default: begin
                n_status = mmst_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= mmst_pkg::CAP_RESET;
            r_fill      <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_gap       <= mmst_pkg::NO_PAIR;
            r_inflight  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_ch.valid) begin
                r_cap <= i_cfg_ch.data;
            end
            if (store) begin
                r_fill <= n_fill;
                if (b < r_min) r_min <= b;
                if (b > r_max) r_max <= b;
            end
            // fold the leaving probe into the best gap
            if (w_link[CELLS].vld && (w_link[CELLS].gap < r_gap)) begin
                r_gap <= w_link[CELLS].gap;
            end
            r_inflight <= r_inflight + IW'(store) - IW'(w_link[CELLS].vld);
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status <= n_status;
            r_short  <= n_short;
            r_long   <= n_long;
            r_count  <= store ? n_fill : r_fill;
        end
    end

    assign o_res_ch.valid         = r_out_valid;
    assign o_res_ch.status        = r_status;
    assign o_res_ch.shortest_span = r_short;
    assign o_res_ch.longest_span  = r_long;
    assign o_res_ch.stored_count  = r_count;

    `MMST_NEVER(a_query_with_probe, in_acc && (i_cmd_ch.cmd == mmst_pkg::CMD_QUERY) && (r_inflight != '0))
    `MMST_NEVER(a_fill_over_cap, r_fill > CAP_MAX)
    `MMST_NEVER(a_exit_without_launch, w_link[CELLS].vld && (r_inflight == '0))
    `MMST_ASSERT(a_store_grows_fill, store |=> (r_fill > $past(r_fill)))

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Span tracker testbench
// Sends adds, repeated adds, span queries and unused codes over valid/ready
// channels, keeps its own copy of the store to predict every result, and checks
// each result beat field by field. Both sides idle at random, and the result
// side holds off once for a long stretch. Capacity is changed between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int unsigned STORE_DEPTH   = mmst_pkg::DEPTH_DEFAULT;
    localparam int          IDLE_PCT      = 17;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          MAX_PRINTED   = 40;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [6:0]         rpt;
    } t_span_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] shortest;
        logic [31:0] longest;
        logic [6:0]  count;
    } t_span_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mmst_cmd_if cmd_ch ();
    mmst_res_if res_ch ();
    mmst_cfg_if cfg_ch ();

    min_max_span_tracker_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Local copy of the tracker
    logic [6:0]         cap_setting;
    logic signed [31:0] held_values [$];
    logic signed [31:0] low_mark;
    logic signed [31:0] high_mark;
    logic [32:0]        best_gap;

    t_span_cmd    pending_items  [$];
    t_span_result expected_spans [$];

    logic cmd_taken   = 1'b0;
    logic steady_run  = 1'b0;
    logic hold_off    = 1'b0;
    logic hold_go     = 1'b0;

    int errors          = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int spans_reported  = 0;
    int overflows       = 0;
    int too_few         = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    function automatic void store_value(input logic signed [31:0] v);
        longint diff;
        foreach (held_values[i]) begin
            diff = longint'(v) - longint'(held_values[i]);
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff < longint'(best_gap)) begin
                best_gap = diff[32:0];
            end
        end
        held_values.push_back(v);
        if (v < low_mark) begin
            low_mark = v;
        end
        if (v > high_mark) begin
            high_mark = v;
        end
    endfunction

    function automatic t_span_result spans_after(input t_span_cmd c);
        t_span_result r;
        int unsigned  cap_eff;
        int unsigned  fill;
        r       = '0;
        cap_eff = (cap_setting > STORE_DEPTH) ? STORE_DEPTH : cap_setting;
        fill    = held_values.size();
        case (c.cmd)
            mmst_pkg::CMD_ADD: begin
                if (fill >= cap_eff) begin
                    r.status = mmst_pkg::ST_OVERFLOW;
                end else begin
                    store_value(c.value);
                end
            end
            mmst_pkg::CMD_REPEAT: begin
                if (c.rpt == 0 || fill + c.rpt > cap_eff) begin
                    r.status = mmst_pkg::ST_OVERFLOW;
                end else begin
                    repeat (c.rpt) store_value(c.value);
                end
            end
            mmst_pkg::CMD_QUERY: begin
                if (fill < 2) begin
                    r.status = mmst_pkg::ST_FEW;
                end else begin
                    r.shortest = best_gap[31:0];
                    r.longest  = high_mark - low_mark;
                end
            end
            default: begin
                // unused code: no change, plain ok
            end
        endcase
        r.count = 7'(held_values.size());
        return r;
    endfunction

    function automatic void queue_item(input logic [1:0] c, input logic signed [31:0] v,
                                       input logic [6:0] n);
        t_span_cmd item;
        item.cmd   = c;
        item.value = v;
        item.rpt   = n;
        pending_items.push_back(item);
    endfunction

    function automatic logic signed [31:0] pick_value(input logic signed [31:0] centre);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            // tight cluster so that small gaps show up
            return centre + $signed($urandom_range(2000)) - 32'sd1000;
        end
        if (roll < 55) begin
            case ($urandom_range(5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh8000_0001;
                2:       return 32'sh7FFF_FFFF;
                3:       return 32'sh7FFF_FFFE;
                4:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Drain everything in flight, then let the probe chain empty out
    task automatic settle();
        while (pending_items.size() != 0 || cmd_ch.valid || expected_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [6:0] cap);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Command driver: hold a beat until taken, else offer the next item
    always @(negedge i_clk) begin
        t_span_cmd next_item;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_ch.valid && !cmd_taken) begin
            // hold
        end else if (pending_items.size() != 0
                     && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
            next_item = pending_items.pop_front();
            cmd_ch.valid        <= 1'b1;
            cmd_ch.cmd          <= next_item.cmd;
            cmd_ch.value        <= next_item.value;
            cmd_ch.repeat_count <= next_item.rpt;
        end else begin
            cmd_ch.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !hold_off && (steady_run || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long result stall while the sender keeps offering
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor: check result beats, then advance the local tracker
    always @(posedge i_clk) begin
        t_span_result want;
        t_span_result predicted;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (res_ch.valid && res_ch.ready) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch("unexpected result beat", res_ch.status, '0);
                end else begin
                    want = expected_spans.pop_front();
                    results_checked++;
                    if (res_ch.status !== want.status) begin
                        report_mismatch("status", res_ch.status, want.status);
                    end
                    if (res_ch.shortest_span !== want.shortest) begin
                        report_mismatch("shortest_span", res_ch.shortest_span, want.shortest);
                    end
                    if (res_ch.longest_span !== want.longest) begin
                        report_mismatch("longest_span", res_ch.longest_span, want.longest);
                    end
                    if (res_ch.stored_count !== want.count) begin
                        report_mismatch("stored_count", res_ch.stored_count, want.count);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                cap_setting = cfg_ch.data;
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                predicted = spans_after({cmd_ch.cmd, cmd_ch.value, cmd_ch.repeat_count});
                expected_spans.push_back(predicted);
                items_taken++;
                if (cmd_ch.cmd == mmst_pkg::CMD_QUERY && predicted.status == mmst_pkg::ST_OK) begin
                    spans_reported++;
                end
                if (predicted.status == mmst_pkg::ST_OVERFLOW) begin
                    overflows++;
                end
                if (predicted.status == mmst_pkg::ST_FEW) begin
                    too_few++;
                end
            end
        end
    end

    initial begin
        logic [6:0]         cap_plan [8];
        logic signed [31:0] centre;
        int unsigned        sel;
        int unsigned        rsel;
        logic [6:0]         n;

        cmd_ch.valid        = 1'b0;
        cmd_ch.cmd          = mmst_pkg::CMD_ADD;
        cmd_ch.value        = '0;
        cmd_ch.repeat_count = '0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        cap_setting         = mmst_pkg::CAP_RESET;
        low_mark            = 32'sh7FFF_FFFF;
        high_mark           = 32'sh8000_0000;
        best_gap            = mmst_pkg::NO_PAIR;
        cap_plan = '{7'd14, 7'd22, 7'd0, 7'd34, 7'd46, 7'd127, 7'd1, 7'd64};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, unused code, zero count, extremes, duplicates
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        queue_item(CMD_UNUSED,           32'sd0, 7'd0);
        queue_item(mmst_pkg::CMD_REPEAT, 32'sd5, 7'd0);
        queue_item(mmst_pkg::CMD_ADD,    32'sh8000_0000, 7'd0);
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        queue_item(mmst_pkg::CMD_ADD,    32'sh7FFF_FFFF, 7'd0);
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        queue_item(mmst_pkg::CMD_REPEAT, 32'sd0, 7'd2);
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        queue_item(mmst_pkg::CMD_REPEAT, -32'sd1, 7'd127);
        queue_item(mmst_pkg::CMD_REPEAT, 32'sd9, 7'd61);
        queue_item(mmst_pkg::CMD_ADD,    -32'sd1, 7'd127);
        queue_item(CMD_UNUSED,           -32'sd1, 7'd127);
        queue_item(mmst_pkg::CMD_QUERY,  -32'sd1, 7'd127);
        settle();

        // Capacity zero rejects every add
        write_capacity(7'd0);
        queue_item(mmst_pkg::CMD_ADD,    32'sd7, 7'd0);
        queue_item(mmst_pkg::CMD_REPEAT, 32'sd7, 7'd1);
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        settle();

        // Capacity below the fill keeps the store but rejects adds
        write_capacity(7'd3);
        queue_item(mmst_pkg::CMD_ADD,    32'sd8, 7'd0);
        queue_item(mmst_pkg::CMD_REPEAT, 32'sd8, 7'd2);
        queue_item(mmst_pkg::CMD_QUERY,  32'sd0, 7'd0);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            write_capacity(cap_plan[phase]);
            centre     = $urandom;
            steady_run = (phase == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(99);
                if (sel < 30) begin
                    queue_item(mmst_pkg::CMD_ADD, pick_value(centre), 7'($urandom_range(127)));
                end else if (sel < 55) begin
                    rsel = $urandom_range(99);
                    if (rsel < 15) begin
                        n = 7'd0;
                    end else if (rsel < 30) begin
                        n = 7'($urandom_range(127));
                    end else begin
                        n = 7'($urandom_range(4, 1));
                    end
                    queue_item(mmst_pkg::CMD_REPEAT, pick_value(centre), n);
                end else if (sel < 92) begin
                    queue_item(mmst_pkg::CMD_QUERY, $urandom, 7'($urandom_range(127)));
                end else begin
                    queue_item(CMD_UNUSED, $urandom, 7'($urandom_range(127)));
                end
            end
            if (phase == 3) begin
                hold_go = 1'b1;
            end
            settle();
            steady_run = 1'b0;
        end

        $display("items %0d, results %0d, span answers %0d, overflows %0d, short stores %0d",
                 items_taken, results_checked, spans_reported, overflows, too_few);
        $display("final fill %0d of %0d, capacity settings 0 to 127, one long result stall",
                 held_values.size(), STORE_DEPTH);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
